### sv/bmtc_pkg.sv
package bmtc_pkg;

   localparam int VC_W  = 5;
   localparam int IDX_W = 4;
   localparam int ROW_W = 16;

   typedef enum logic [1:0] {
      MODE_SET    = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_CLEAR  = 2'd2,
      MODE_CLOSE  = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type               mode;
      logic [IDX_W-1:0]       src;
      logic [IDX_W-1:0]       dst;
   } req_type;

   typedef struct packed {
      logic [ROW_W-1:0]       row_bits;
      logic                   index_error;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERR,
      ST_EDIT_RD,
      ST_EDIT_WR,
      ST_CLEAR,
      ST_PIV_RD,
      ST_PIV_LD,
      ST_ROW,
      ST_DRAIN,
      ST_FIN_RD,
      ST_FIN_OUT
   } step_type;

   typedef enum logic [1:0] {
      RD_NONE,
      RD_SRC,
      RD_K,
      RD_I
   } rd_sel_type;

   typedef enum logic [2:0] {
      RES_NONE,
      RES_ERR,
      RES_ZERO,
      RES_EDIT,
      RES_ROW
   } res_sel_type;

   typedef enum logic [2:0] {
      JC_NEXT,
      JC_GOTO,
      JC_DISPATCH,
      JC_LOOP_I,
      JC_LOOP_K
   } jump_type;

   typedef struct packed {
      logic          take;
      rd_sel_type    rd;
      logic          clr_i;
      logic          inc_i;
      logic          clr_k;
      logic          inc_k;
      logic          ld_pivot;
      logic          wr_edit;
      logic          clr_valid;
      res_sel_type   res;
      jump_type      jc;
      step_type      target;
   } ctrl_word_type;

   typedef struct packed {
      logic          start;
      logic          err;
      mode_type      mode;
      logic          i_last;
      logic          k_last;
      logic          out_free;
   } seq_status_type;

   // Control store: one word per step.
   function automatic ctrl_word_type microcode(input step_type step);
      ctrl_word_type cw;
      cw = '0;
      unique case (step)
         ST_IDLE: begin
            cw.take  = 1'b1;
            cw.clr_k = 1'b1;
            cw.jc    = JC_DISPATCH;
         end
         ST_ERR: begin
            cw.res    = RES_ERR;
            cw.jc     = JC_GOTO;
            cw.target = ST_IDLE;
         end
         ST_EDIT_RD: begin
            cw.rd = RD_SRC;
            cw.jc = JC_NEXT;
         end
         ST_EDIT_WR: begin
            cw.wr_edit = 1'b1;
            cw.res     = RES_EDIT;
            cw.jc      = JC_GOTO;
            cw.target  = ST_IDLE;
         end
         ST_CLEAR: begin
            cw.clr_valid = 1'b1;
            cw.res       = RES_ZERO;
            cw.jc        = JC_GOTO;
            cw.target    = ST_IDLE;
         end
         ST_PIV_RD: begin
            cw.rd    = RD_K;
            cw.clr_i = 1'b1;
            cw.jc    = JC_NEXT;
         end
         ST_PIV_LD: begin
            cw.ld_pivot = 1'b1;
            cw.jc       = JC_NEXT;
         end
         ST_ROW: begin
            cw.rd     = RD_I;
            cw.inc_i  = 1'b1;
            cw.jc     = JC_LOOP_I;
            cw.target = ST_ROW;
         end
         ST_DRAIN: begin
            cw.inc_k  = 1'b1;
            cw.jc     = JC_LOOP_K;
            cw.target = ST_PIV_RD;
         end
         ST_FIN_RD: begin
            cw.rd = RD_SRC;
            cw.jc = JC_NEXT;
         end
         ST_FIN_OUT: begin
            cw.res    = RES_ROW;
            cw.jc     = JC_GOTO;
            cw.target = ST_IDLE;
         end
         default: begin
            cw.jc     = JC_GOTO;
            cw.target = ST_IDLE;
         end
      endcase
      return cw;
   endfunction

endpackage

### sv/bmtc_ram.sv
module bmtc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/bmtc_seq.sv
module bmtc_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  bmtc_pkg::seq_status_type status,
   output bmtc_pkg::ctrl_word_type  cw
);

   import bmtc_pkg::*;

   step_type      step_ff;
   step_type      step_in;
   ctrl_word_type cw_rom;
   logic          hold;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   // A step that drives a result waits while the output register holds a result that is stalled.
   always_comb begin
      cw_rom  = microcode(step_ff);
      hold    = (cw_rom.res != RES_NONE) && !status.out_free;
      step_in = step_ff;
      cw      = cw_rom;
      if (hold) begin
         cw.wr_edit   = 1'b0;
         cw.clr_valid = 1'b0;
         cw.res       = RES_NONE;
      end else begin
         unique case (cw_rom.jc)
            JC_NEXT:  step_in = step_type'(step_ff + 4'd1);
            JC_GOTO:  step_in = cw_rom.target;
            JC_DISPATCH: begin
               if (status.start) begin
                  if (status.err) begin
                     step_in = ST_ERR;
                  end else begin
                     unique case (status.mode)
                        MODE_SET, MODE_REMOVE: step_in = ST_EDIT_RD;
                        MODE_CLEAR:            step_in = ST_CLEAR;
                        MODE_CLOSE:            step_in = ST_PIV_RD;
                        default:               step_in = ST_IDLE;
                     endcase
                  end
               end
            end
            JC_LOOP_I: step_in = status.i_last ? step_type'(step_ff + 4'd1) : cw_rom.target;
            JC_LOOP_K: step_in = status.k_last ? step_type'(step_ff + 4'd1) : cw_rom.target;
            default:   step_in = ST_IDLE;
         endcase
      end
   end

endmodule

### sv/bit_matrix_transitive_closure_top.sv
// An index error goes to the error step and a clear to the clear step; an edge set or
// remove reads the source row, then writes it; a closure, for each pivot k below the
// effective vertex count n, loads row k and sweeps all n rows, then reads the source row.
// A new beat is taken in the idle step that follows each result; a waiting result does
// not block the next beat, only that beat's own result.
// Synchronous active-high reset empties the matrix and sets the vertex count to 16.
module bit_matrix_transitive_closure_top #(
   parameter int MAX_VERTICES = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  bmtc_pkg::req_type               req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output bmtc_pkg::rsp_type               rsp_payload,
   input  logic                            csr_wr_en,
   input  logic [bmtc_pkg::VC_W-1:0]       csr_wr_data
);

   import bmtc_pkg::*;

   localparam int RowW = MAX_VERTICES;
   localparam int IdxW = $clog2(MAX_VERTICES);

   // Effective vertex count: zero reads as one, values above the matrix size saturate.
   function automatic logic [VC_W-1:0] eff_count(input logic [VC_W-1:0] v);
      if (v == '0) begin
         return VC_W'(1);
      end
      if (int'(v) > MAX_VERTICES) begin
         return VC_W'(MAX_VERTICES);
      end
      return v;
   endfunction

   // Control and configuration registers.
   logic [VC_W-1:0]         n_ff;
   logic [IdxW-1:0]         i_ff, i_in;
   logic [IdxW-1:0]         k_ff, k_in;
   logic                    pend_ff;
   logic [IdxW-1:0]         pend_addr_ff;
   logic [MAX_VERTICES-1:0] row_valid_ff, row_valid_in;
   logic                    rd_valid_ff;
   logic                    rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   req_type                 item_ff;
   logic [RowW-1:0]         pivot_ff;
   rsp_type                 rsp_ff, rsp_in;

   ctrl_word_type           cw;
   seq_status_type          status;

   logic                    accept;
   logic                    req_err;
   logic [RowW-1:0]         cols;
   logic                    rd_en;
   logic [IdxW-1:0]         rd_addr;
   logic [RowW-1:0]         ram_rd_data;
   logic [RowW-1:0]         row_rd;
   logic [RowW-1:0]         edit_mask;
   logic [RowW-1:0]         edit_row;
   logic [IdxW-1:0]         src_addr;
   logic                    wb_en;
   logic                    wr_en;
   logic [IdxW-1:0]         wr_addr;
   logic [RowW-1:0]         wr_data;

   // A beat is taken only in the idle step; reset blocks it so nothing slips in.
   assign req_stall = reset || !cw.take;
   assign accept    = req_valid && !req_stall;

   assign req_err = (VC_W'(req_payload.src) >= n_ff) || (VC_W'(req_payload.dst) >= n_ff);

   always_comb begin
      for (int j = 0; j < RowW; j++) begin
         cols[j] = (j < int'(n_ff));
      end
   end

   assign status.start    = accept;
   assign status.err      = req_err;
   assign status.mode     = req_payload.mode;
   assign status.i_last   = (int'(i_ff) == int'(n_ff) - 1);
   assign status.k_last   = (int'(k_ff) == int'(n_ff) - 1);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   bmtc_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cw     (cw)
   );

   // Read address selection for the single read port.
   assign src_addr = IdxW'(item_ff.src);

   always_comb begin
      rd_en   = 1'b1;
      rd_addr = src_addr;
      unique case (cw.rd)
         RD_NONE: rd_en   = 1'b0;
         RD_SRC:  rd_addr = src_addr;
         RD_K:    rd_addr = k_ff;
         RD_I:    rd_addr = i_ff;
         default: rd_en   = 1'b0;
      endcase
   end

   // Rows that were never written since reset or the last clear read as zero.
   assign row_rd = rd_valid_ff ? ram_rd_data : '0;

   // Edge edit on the row just read.
   assign edit_mask = RowW'(1) << item_ff.dst;
   assign edit_row  = (item_ff.mode == MODE_SET) ? (row_rd | edit_mask) : (row_rd & ~edit_mask);

   // Closure write-back: the row read last cycle absorbs the pivot row when it reaches
   // the pivot vertex. Rows are read one per cycle, so writes never meet a read of the
   // same row.
   assign wb_en = pend_ff && row_rd[k_ff];

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pend_addr_ff;
      wr_data = row_rd | pivot_ff;
      if (cw.wr_edit) begin
         wr_en   = 1'b1;
         wr_addr = src_addr;
         wr_data = edit_row;
      end else if (wb_en) begin
         wr_en = 1'b1;
      end
   end

   bmtc_ram #(
      .WIDTH (RowW),
      .DEPTH (MAX_VERTICES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // Counters and row valid bits.
   always_comb begin
      i_in = i_ff;
      if (cw.clr_i) begin
         i_in = '0;
      end else if (cw.inc_i) begin
         i_in = i_ff + IdxW'(1);
      end
      k_in = k_ff;
      if (cw.clr_k) begin
         k_in = '0;
      end else if (cw.inc_k) begin
         k_in = k_ff + IdxW'(1);
      end
      row_valid_in = row_valid_ff;
      if (cw.clr_valid) begin
         row_valid_in = '0;
      end else if (wr_en) begin
         row_valid_in[wr_addr] = 1'b1;
      end
   end

   // Result selection into the output register.
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (cw.res)
         RES_NONE: begin
         end
         RES_ERR: begin
            rsp_valid_in        = 1'b1;
            rsp_in.row_bits     = '0;
            rsp_in.index_error  = 1'b1;
         end
         RES_ZERO: begin
            rsp_valid_in        = 1'b1;
            rsp_in.row_bits     = '0;
            rsp_in.index_error  = 1'b0;
         end
         RES_EDIT: begin
            rsp_valid_in        = 1'b1;
            rsp_in.row_bits     = ROW_W'(edit_row & cols);
            rsp_in.index_error  = 1'b0;
         end
         RES_ROW: begin
            rsp_valid_in        = 1'b1;
            rsp_in.row_bits     = ROW_W'(row_rd & cols);
            rsp_in.index_error  = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff         <= eff_count(VC_W'(16));
         i_ff         <= '0;
         k_ff         <= '0;
         pend_ff      <= 1'b0;
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            n_ff <= eff_count(csr_wr_data);
         end
         i_ff         <= i_in;
         k_ff         <= k_in;
         pend_ff      <= (cw.rd == RD_I);
         row_valid_ff <= row_valid_in;
         if (rd_en) begin
            rd_valid_ff <= row_valid_ff[rd_addr];
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_payload;
      end
      if (cw.rd == RD_I) begin
         pend_addr_ff <= i_ff;
      end
      // The pivot row is masked to the columns in use before it spreads.
      if (cw.ld_pivot) begin
         pivot_ff <= row_rd & cols;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
